// ===== rtl/sit_pkg.sv =====
// Shared types and constants of the string intern table.
// No dependencies; imported by every module of the block.
package sit_pkg;

   localparam int DEF_POOL_ENTRIES  = 1024;
   localparam int DEF_MAX_CHARS     = 32;
   localparam int DEF_START_BUCKETS = 16;
   localparam int DEF_MAX_BUCKETS   = 2048;

   localparam int HANDLE_W = 10;
   localparam int STATUS_W = 2;
   localparam int HASH_W   = 32;

   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND    = 2'd0,
      ST_INSERTED = 2'd1,
      ST_TOO_LONG = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      status_type          status;
      logic [HASH_W-1:0]   hash_value;
   } result_type;

endpackage

// ===== rtl/sit_hash.sv =====
// Iterative string hash: folds one byte per cycle, last byte first.
// Depends on sit_pkg.
module sit_hash
   import sit_pkg::*;
#(
   parameter int MAX_CHARS = DEF_MAX_CHARS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [$clog2(MAX_CHARS+1)-1:0] len_in,
   input  logic [MAX_CHARS-1:0][7:0]    chars_in,
   output logic                         done,
   output logic [HASH_W-1:0]            hash_out
);
   localparam int CLW = $clog2(MAX_CHARS+1);
   localparam int CHW = $clog2(MAX_CHARS);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CLW-1:0]  idx_ff, idx_in, idx_m1;
   logic [63:0]     h_ff, h_in;
   logic [7:0]      cur_byte;

   always_comb begin
      idx_m1   = idx_ff - CLW'(1);
      cur_byte = chars_in[idx_m1[CHW-1:0]];
      busy_in  = busy_ff;
      done_in  = 1'b0;
      idx_in   = idx_ff;
      h_in     = h_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = len_in;
         h_in    = 64'(len_in);
      end else if (busy_ff) begin
         if (idx_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            h_in   = h_ff ^ ((h_ff << 5) + (h_ff >> 2) + 64'(cur_byte));
            idx_in = idx_m1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff <= idx_in;
      h_ff   <= h_in;
   end

   // zero hash maps to one
   assign hash_out = (h_ff == 64'd0) ? HASH_W'(1) : h_ff[HASH_W-1:0];
   assign done     = done_ff;

endmodule

// ===== rtl/sit_table.sv =====
// Chained hash table: bucket head RAM, entry RAM, lookup, insert and rehash.
// Depends on sit_pkg.
module sit_table
   import sit_pkg::*;
#(
   parameter int POOL_ENTRIES  = DEF_POOL_ENTRIES,
   parameter int MAX_CHARS     = DEF_MAX_CHARS,
   parameter int START_BUCKETS = DEF_START_BUCKETS,
   parameter int MAX_BUCKETS   = DEF_MAX_BUCKETS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [HASH_W-1:0]              hash_in,
   input  logic [$clog2(MAX_CHARS+1)-1:0] len_in,
   input  logic [MAX_CHARS-1:0][7:0]      chars_in,
   output logic                           done,
   output result_type                     result
);
   localparam int CLW       = $clog2(MAX_CHARS+1);
   localparam int IW        = $clog2(POOL_ENTRIES);
   localparam int AW        = $clog2(MAX_BUCKETS+1) - 1;
   localparam int LGW       = $clog2(AW+1);
   localparam int START_LOG = $clog2(START_BUCKETS+1) - 1;
   localparam int LDW       = (IW + 4 > AW + 3) ? IW + 4 : AW + 3;

   typedef struct packed {
      logic [IW:0]                 next;
      logic [CLW-1:0]              len;
      logic [HASH_W-1:0]           hash;
      logic [MAX_CHARS-1:0][7:0]   chars;
   } meta_type;

   typedef enum logic [11:0] {
      T_IDLE   = 12'b000000000001,
      T_LOOK   = 12'b000000000010,
      T_HEAD   = 12'b000000000100,
      T_NODE   = 12'b000000001000,
      T_CMP    = 12'b000000010000,
      T_MISS   = 12'b000000100000,
      T_CLR    = 12'b000001000000,
      T_RH_RD  = 12'b000010000000,
      T_RH_HD  = 12'b000100000000,
      T_RH_WR  = 12'b001000000000,
      T_INS    = 12'b010000000000,
      T_INS_WR = 12'b100000000000
   } tstate_type;

   localparam logic [IW:0] EMPTY = '1;

   tstate_type         state_ff, state_in;
   logic [HASH_W-1:0]  hash_ff, hash_in_d;
   logic [CLW-1:0]     len_ff, len_in_d;
   logic [IW:0]        node_ff, node_in;
   logic [LGW-1:0]     log_ff, log_in;
   logic [IW:0]        used_ff, used_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [IW-1:0]      ent_ff, ent_in;
   logic               done_ff, done_in;
   result_type         rsp_ff, rsp_in;

   logic [IW:0]        heads_mem [0:(1<<AW)-1];
   logic [IW:0]        heads_rd_ff;
   logic               heads_re, heads_we;
   logic [AW-1:0]      heads_ra, heads_wa;
   logic [IW:0]        heads_wd;

   meta_type           meta_mem [0:POOL_ENTRIES-1];
   meta_type           meta_rd_ff;
   logic               meta_re, meta_we;
   logic [IW-1:0]      meta_ra, meta_wa;
   meta_type           meta_wd;

   logic [AW-1:0]      mask;
   logic [LGW:0]       new_log;
   logic               grow_ok, load_hi, chars_eq;
   logic [LDW-1:0]     load_lhs, load_rhs;
   logic [HANDLE_W+IW:0] node_wide, used_wide;

   always_comb begin
      mask     = ~({AW{1'b1}} << log_ff);
      new_log  = (LGW+1)'(log_ff) + (LGW+1)'(1);
      if (new_log < (LGW+1)'(START_LOG)) new_log = (LGW+1)'(START_LOG);
      grow_ok  = (new_log <= (LGW+1)'(AW));
      load_lhs = (LDW'(used_ff) << 2) + LDW'(used_ff);
      load_rhs = LDW'(4) << log_ff;
      load_hi  = (load_lhs >= load_rhs);
      chars_eq = 1'b1;
      for (int i = 0; i < MAX_CHARS; i++) begin
         if ((CLW'(i) < len_ff) && (meta_rd_ff.chars[i] != chars_in[i])) chars_eq = 1'b0;
      end
      node_wide = {{HANDLE_W{1'b0}}, node_ff};
      used_wide = {{HANDLE_W{1'b0}}, used_ff};
   end

   always_comb begin
      state_in  = state_ff;
      hash_in_d = hash_ff;
      len_in_d  = len_ff;
      node_in   = node_ff;
      log_in    = log_ff;
      used_in   = used_ff;
      clr_in    = clr_ff;
      ent_in    = ent_ff;
      done_in   = 1'b0;
      rsp_in    = rsp_ff;
      heads_re  = 1'b0;
      heads_ra  = hash_ff[AW-1:0] & mask;
      heads_we  = 1'b0;
      heads_wa  = hash_ff[AW-1:0] & mask;
      heads_wd  = EMPTY;
      meta_re   = 1'b0;
      meta_ra   = node_ff[IW-1:0];
      meta_we   = 1'b0;
      meta_wa   = ent_ff;
      meta_wd   = meta_rd_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (start) begin
               hash_in_d = hash_in;
               len_in_d  = len_in;
               state_in  = (log_ff == '0) ? T_MISS : T_LOOK;
            end
         end
         T_LOOK: begin
            heads_re = 1'b1;
            state_in = T_HEAD;
         end
         T_HEAD: begin
            node_in  = heads_rd_ff;
            state_in = T_NODE;
         end
         T_NODE: begin
            if (node_ff[IW]) begin
               state_in = T_MISS;
            end else begin
               meta_re  = 1'b1;
               state_in = T_CMP;
            end
         end
         T_CMP: begin
            if (meta_rd_ff.hash == hash_ff && meta_rd_ff.len == len_ff && chars_eq) begin
               done_in           = 1'b1;
               rsp_in.handle     = node_wide[HANDLE_W-1:0];
               rsp_in.status     = ST_FOUND;
               rsp_in.hash_value = hash_ff;
               state_in          = T_IDLE;
            end else begin
               node_in  = meta_rd_ff.next;
               state_in = T_NODE;
            end
         end
         T_MISS: begin
            if (used_ff >= (IW+1)'(POOL_ENTRIES)) begin
               done_in           = 1'b1;
               rsp_in.handle     = '0;
               rsp_in.status     = ST_FULL;
               rsp_in.hash_value = hash_ff;
               state_in          = T_IDLE;
            end else if ((log_ff == '0 || load_hi) && grow_ok) begin
               log_in   = new_log[LGW-1:0];
               clr_in   = '0;
               state_in = T_CLR;
            end else begin
               state_in = T_INS;
            end
         end
         T_CLR: begin
            heads_we = 1'b1;
            heads_wa = clr_ff;
            heads_wd = EMPTY;
            clr_in   = clr_ff + AW'(1);
            if (clr_ff == mask) begin
               ent_in   = '0;
               state_in = (used_ff == '0) ? T_INS : T_RH_RD;
            end
         end
         T_RH_RD: begin
            meta_re  = 1'b1;
            meta_ra  = ent_ff;
            state_in = T_RH_HD;
         end
         T_RH_HD: begin
            heads_re = 1'b1;
            heads_ra = meta_rd_ff.hash[AW-1:0] & mask;
            state_in = T_RH_WR;
         end
         T_RH_WR: begin
            // push entry onto the head of its new chain
            meta_we      = 1'b1;
            meta_wa      = ent_ff;
            meta_wd      = meta_rd_ff;
            meta_wd.next = heads_rd_ff;
            heads_we     = 1'b1;
            heads_wa     = meta_rd_ff.hash[AW-1:0] & mask;
            heads_wd     = {1'b0, ent_ff};
            ent_in       = ent_ff + IW'(1);
            state_in     = ({1'b0, ent_ff} == used_ff - (IW+1)'(1)) ? T_INS : T_RH_RD;
         end
         T_INS: begin
            heads_re = 1'b1;
            state_in = T_INS_WR;
         end
         T_INS_WR: begin
            meta_we           = 1'b1;
            meta_wa           = used_ff[IW-1:0];
            meta_wd.next      = heads_rd_ff;
            meta_wd.len       = len_ff;
            meta_wd.hash      = hash_ff;
            meta_wd.chars     = chars_in;
            heads_we          = 1'b1;
            heads_wd          = used_ff;
            used_in           = used_ff + (IW+1)'(1);
            done_in           = 1'b1;
            rsp_in.handle     = used_wide[HANDLE_W-1:0];
            rsp_in.status     = ST_INSERTED;
            rsp_in.hash_value = hash_ff;
            state_in          = T_IDLE;
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (heads_we) heads_mem[heads_wa] <= heads_wd;
      if (heads_re) heads_rd_ff <= heads_mem[heads_ra];
      if (meta_we)  meta_mem[meta_wa] <= meta_wd;
      if (meta_re)  meta_rd_ff <= meta_mem[meta_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         log_ff   <= '0;
         used_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         log_ff   <= log_in;
         used_ff  <= used_in;
         done_ff  <= done_in;
      end
      hash_ff <= hash_in_d;
      len_ff  <= len_in_d;
      node_ff <= node_in;
      clr_ff  <= clr_in;
      ent_ff  <= ent_in;
      rsp_ff  <= rsp_in;
   end

   assign done   = done_ff;
   assign result = rsp_ff;

endmodule

// ===== rtl/string_intern_table_unit.sv =====
// String intern table, top level: byte collection, hash and result register.
// Depends on sit_pkg, sit_hash and sit_table.
//
// A string arrives one byte word per cycle on req_ while req_ready is high;
// the word with is_last closes it (an empty string is one word with has_byte
// low). Each closed string yields one rsp_ word: the handle of the pool entry
// holding that string (found or newly inserted), a status, and the 32-bit
// hash. Strings of MAX_CHARS bytes or more answer "too long" at once and are
// not stored; a miss with the pool full answers "pool full". Bytes are taken
// at one per cycle while collecting. At a string end the hash unit folds one
// byte per cycle, then the table reads the bucket head and walks the chain,
// reading and comparing each entry; an insert reads the bucket head again
// and writes the new entry at its chain head. A growth step clears the new
// bucket range (one head per cycle) and rehashes every stored entry: read it,
// read its new bucket head, write both. No clearing pass follows reset: the
// bucket RAM is first swept when the table first grows.
module string_intern_table_unit
   import sit_pkg::*;
#(
   parameter int POOL_ENTRIES  = DEF_POOL_ENTRIES,
   parameter int MAX_CHARS     = DEF_MAX_CHARS,
   parameter int START_BUCKETS = DEF_START_BUCKETS,
   parameter int MAX_BUCKETS   = DEF_MAX_BUCKETS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_char_byte,
   input  logic                req_has_byte,
   input  logic                req_is_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [HANDLE_W-1:0] rsp_handle,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [HASH_W-1:0]   rsp_hash_value
);
   localparam int CLW = $clog2(MAX_CHARS+1);
   localparam int CHW = $clog2(MAX_CHARS);

   typedef enum logic [4:0] {
      C_COLLECT = 5'b00001,
      C_HSTART  = 5'b00010,
      C_HWAIT   = 5'b00100,
      C_TWAIT   = 5'b01000,
      C_PEND    = 5'b10000
   } cstate_type;

   cstate_type                 state_ff, state_in;
   logic [CLW-1:0]             len_ff, len_in, len_next;
   logic [MAX_CHARS-1:0][7:0]  chars_ff;
   result_type                 pend_ff, pend_in;
   result_type                 out_ff, out_in;
   logic                       out_valid_ff, out_valid_in;
   logic                       accept, take_byte;
   logic                       hash_start, hash_done, tbl_done;
   logic [HASH_W-1:0]          hash_val;
   result_type                 tbl_result;

   assign req_ready = (state_ff == C_COLLECT);
   assign accept    = req_valid && req_ready;
   assign take_byte = accept && req_has_byte && (len_ff < CLW'(MAX_CHARS));
   assign len_next  = take_byte ? len_ff + CLW'(1) : len_ff;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      pend_in      = pend_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      hash_start   = 1'b0;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      unique case (state_ff)
         C_COLLECT: begin
            if (accept) begin
               len_in = len_next;
               if (req_is_last) begin
                  if (len_next >= CLW'(MAX_CHARS)) begin
                     pend_in.handle     = '0;
                     pend_in.status     = ST_TOO_LONG;
                     pend_in.hash_value = '0;
                     state_in           = C_PEND;
                  end else begin
                     state_in = C_HSTART;
                  end
               end
            end
         end
         C_HSTART: begin
            hash_start = 1'b1;
            state_in   = C_HWAIT;
         end
         C_HWAIT: begin
            if (hash_done) state_in = C_TWAIT;
         end
         C_TWAIT: begin
            if (tbl_done) begin
               pend_in  = tbl_result;
               state_in = C_PEND;
            end
         end
         C_PEND: begin
            // hand off once the output word is free
            if (!out_valid_ff || rsp_ready) begin
               out_in       = pend_ff;
               out_valid_in = 1'b1;
               len_in       = '0;
               state_in     = C_COLLECT;
            end
         end
         default: state_in = C_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_COLLECT;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
      end
      if (take_byte) chars_ff[len_ff[CHW-1:0]] <= req_char_byte;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   sit_hash #(
      .MAX_CHARS(MAX_CHARS)
   ) u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hash_start),
      .len_in   (len_ff),
      .chars_in (chars_ff),
      .done     (hash_done),
      .hash_out (hash_val)
   );

   sit_table #(
      .POOL_ENTRIES  (POOL_ENTRIES),
      .MAX_CHARS     (MAX_CHARS),
      .START_BUCKETS (START_BUCKETS),
      .MAX_BUCKETS   (MAX_BUCKETS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .start    (hash_done),
      .hash_in  (hash_val),
      .len_in   (len_ff),
      .chars_in (chars_ff),
      .done     (tbl_done),
      .result   (tbl_result)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_handle     = out_ff.handle;
   assign rsp_status     = out_ff.status;
   assign rsp_hash_value = out_ff.hash_value;

endmodule

// ===== test/tb_string_intern_table_unit.sv =====
// Testbench for string_intern_table_unit: strings go in one byte word at a
// time, each closed string is interned by a local table model and checked.
// Depends on sit_pkg and the string_intern_table_unit RTL.
module tb_string_intern_table_unit;
   import sit_pkg::*;

   localparam int POOL   = DEF_POOL_ENTRIES;
   localparam int CHARS  = DEF_MAX_CHARS;
   localparam int BUCKMAX = DEF_MAX_BUCKETS;
   localparam int NIL    = -1;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_char_byte = 8'd0;
   logic                req_has_byte = 1'b0;
   logic                req_is_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [HANDLE_W-1:0] rsp_handle;
   logic [STATUS_W-1:0] rsp_status;
   logic [HASH_W-1:0]   rsp_hash_value;

   string_intern_table_unit dut (.*);

   initial forever #1 clock = ~clock;

   // Run limit, far above the slowest correct run.
   initial begin
      #2000000;
      $display("tb_string_intern_table_unit: done, errors");
      $finish;
   end

   typedef struct {
      logic [HANDLE_W-1:0] handle;
      status_type          status;
      logic [HASH_W-1:0]   hash;
   } interned_type;

   interned_type pending_results[$];
   int         mismatches = 0;
   int         send_idle = 0;    // percent of cycles the sender sits idle
   int         recv_stall = 0;   // percent of cycles the receiver stalls
   int         hold_off = 0;     // long receiver hold-off, in cycles

   // Local copy of the table.
   logic [7:0]  open_bytes [CHARS];
   int          open_len;
   logic [7:0]  pool_bytes [POOL][CHARS];
   int          pool_len [POOL];
   logic [31:0] pool_hash [POOL];
   int          pool_link [POOL];
   int          heads [BUCKMAX];
   int          bucket_log;
   int          pool_used;

   function automatic logic [31:0] fold_hash();
      logic [63:0] h;
      h = 64'(open_len);
      for (int i = open_len; i >= 1; i--)
         h ^= (h << 5) + (h >> 2) + 64'(open_bytes[i-1]);
      if (h == 64'd0) h = 64'd1;
      return h[31:0];
   endfunction

   // Double the buckets (minimum 16) and relink every chain.
   task automatic grow_buckets();
      int fresh [BUCKMAX];
      int new_log, old_count, n, following, slot;
      logic [31:0] mask;
      new_log = (bucket_log + 1 < 4) ? 4 : bucket_log + 1;
      if ((1 << new_log) > BUCKMAX) return;
      old_count = bucket_log ? (1 << bucket_log) : 0;
      mask = (32'd1 << new_log) - 1;
      foreach (fresh[b]) fresh[b] = NIL;
      for (int b = 0; b < old_count; b++) begin
         n = heads[b];
         while (n != NIL) begin
            following = pool_link[n];
            slot = int'(pool_hash[n] & mask);
            pool_link[n] = fresh[slot];
            fresh[slot] = n;
            n = following;
         end
      end
      heads = fresh;
      bucket_log = new_log;
   endtask

   // Update the model with one accepted word; queue a result on is_last.
   task automatic intern_word(logic [7:0] ch, logic has, logic last);
      interned_type r;
      int n, slot;
      bit same;
      if (has && open_len < CHARS) begin
         open_bytes[open_len] = ch;
         open_len++;
      end
      if (!last) return;
      r.handle = '0;
      if (open_len >= CHARS) begin
         r.status = ST_TOO_LONG;
         r.hash = '0;
      end else begin
         r.hash = fold_hash();
         r.status = ST_INSERTED;
         n = NIL;
         if (bucket_log) n = heads[r.hash & ((32'd1 << bucket_log) - 1)];
         while (n != NIL) begin
            same = pool_hash[n] == r.hash && pool_len[n] == open_len;
            for (int i = 0; i < open_len; i++)
               if (pool_bytes[n][i] != open_bytes[i]) same = 0;
            if (same) break;
            n = pool_link[n];
         end
         if (n != NIL) begin
            r.status = ST_FOUND;
            r.handle = HANDLE_W'(n);
         end else if (pool_used >= POOL) begin
            r.status = ST_FULL;
         end else begin
            if (bucket_log == 0 || pool_used * 5 >= (1 << bucket_log) * 4)
               grow_buckets();
            for (int i = 0; i < open_len; i++) pool_bytes[pool_used][i] = open_bytes[i];
            pool_len[pool_used] = open_len;
            pool_hash[pool_used] = r.hash;
            slot = int'(r.hash & ((32'd1 << bucket_log) - 1));
            pool_link[pool_used] = heads[slot];
            heads[slot] = pool_used;
            r.handle = HANDLE_W'(pool_used);
            pool_used++;
         end
      end
      open_len = 0;
      pending_results.push_back(r);
   endtask

   // Offer one word; valid is raised once and held until accepted.
   task automatic send_word(logic [7:0] ch, logic has, logic last);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid     <= 1'b1;
      req_char_byte <= ch;
      req_has_byte  <= has;
      req_is_last   <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      intern_word(ch, has, last);
   endtask

   // Send a string; optionally close it with an empty last word and
   // sprinkle ignored words (no byte, not last) in between.
   task automatic send_string(logic [7:0] s[$], bit empty_tail = 0, bit noise = 0);
      if (s.size() == 0) begin
         send_word(8'($urandom), 1'b0, 1'b1);
         return;
      end
      foreach (s[i]) begin
         if (noise && $urandom_range(7) == 0) send_word(8'($urandom), 1'b0, 1'b0);
         send_word(s[i], 1'b1, !empty_tail && i == s.size() - 1);
      end
      if (empty_tail) send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic random_string(int max_len);
      logic [7:0] s[$];
      int len;
      len = ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(max_len);
      repeat (len)
         s.push_back($urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom));
      send_string(s, $urandom_range(9) == 0, $urandom_range(5) == 0);
   endtask

   // Drop valid, then wait for every queued result.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Result checker and receiver ready, one process.
   initial begin
      interned_type e;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: handle %0d status %0d hash %h",
                           rsp_handle, rsp_status, rsp_hash_value);
            end else begin
               e = pending_results.pop_front();
               if (rsp_handle !== e.handle || rsp_status !== e.status ||
                   rsp_hash_value !== e.hash) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp h %0d s %0d x %h, got h %0d s %0d x %h",
                              e.handle, e.status, e.hash,
                              rsp_handle, rsp_status, rsp_hash_value);
               end
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   task automatic test_directed();
      logic [7:0] s[$];
      send_string(s);                        // empty string, inserted
      send_string(s);                        // found
      s = {8'h00}; send_string(s);
      s = {8'hff}; send_string(s);
      s = {8'h00}; send_string(s, 1);        // found, closed by empty word
      s = {8'h41, 8'h42}; send_string(s, 0, 1);
      s = {8'h42, 8'h41}; send_string(s);
      s = {8'h41, 8'h42}; send_string(s);
      s.delete(); repeat (31) s.push_back(8'($urandom)); send_string(s);
      send_string(s);                        // longest stored string, found
      s.push_back(8'h55); send_string(s);    // exactly the limit: too long
      s.push_back(8'haa); send_string(s);
      s.delete(); repeat (31) s.push_back(8'hff); send_string(s, 1);
      s.delete(); repeat (31) s.push_back(8'h00); s.push_back(8'h00); send_string(s);
      wait_drained();
   endtask

   task automatic test_random(int strings);
      repeat (strings) random_string(6);
      wait_drained();
   endtask

   // Receiver holds off long enough that the block backs up its input.
   task automatic test_backpressure();
      send_idle = 0;
      recv_stall = 0;
      hold_off = 400;
      repeat (40) random_string(4);
      wait_drained();
   endtask

   // Fill the pool with short distinct strings, then check full and found.
   task automatic test_pool_full();
      logic [7:0] s[$];
      int k = 0;
      send_idle = 0;
      recv_stall = 20;
      while (pool_used < POOL) begin
         if (k < 256) s = {8'(k)};
         else s = {8'(k - 256), 8'((k - 256) >> 8)};
         send_string(s);
         k++;
      end
      s = {8'h5a, 8'h5a, 8'h5a, 8'h5a}; send_string(s);   // pool full
      s = {8'h07}; send_string(s);                         // still found
      s.delete(); send_string(s);
      repeat (30) random_string(8);
      wait_drained();
   endtask

   initial begin
      open_len = 0;
      pool_used = 0;
      bucket_log = 0;
      foreach (heads[b]) heads[b] = NIL;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle = 0;  recv_stall = 0;  test_random(30);
      send_idle = 72; recv_stall = 0;  test_random(30);
      send_idle = 0;  recv_stall = 72; test_random(30);
      send_idle = 8;  recv_stall = 8;  test_random(30);
      send_idle = 72; recv_stall = 72; test_random(10);
      test_backpressure();
      test_pool_full();
      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("tb_string_intern_table_unit: done, clean");
      else
         $display("tb_string_intern_table_unit: done, errors");
      $finish;
   end

endmodule
